>>> src/wfhd_pkg.sv
// Shared constants, opcodes and command struct of the waveform prefix-code decoder.
`timescale 1ns / 1ps
`default_nettype none
package wfhd_pkg;

  localparam int NODES_DEF        = 512;
  localparam int CHANNELS_DEF     = 12;
  localparam int MAX_CODE_LEN_DEF = 16;

  localparam int OPC_W    = 2;
  localparam int CODE_W   = 16;
  localparam int LEN_W    = 5;
  localparam int SYM_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int SKIP_W   = 5;
  localparam int RAW_BITS = 12;

  localparam logic [OPC_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OPC_W-1:0] OP_DATA    = 2'd1;
  localparam logic [OPC_W-1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic load;
    logic data;
    logic restart;
  } wfhd_cmd_t;

endpackage
`default_nettype wire

>>> src/wfhd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wfhd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/wfhd_loader.sv
// Code insertion sequencer: walks and extends the node table one code bit at a time.
`timescale 1ns / 1ps
`default_nettype none
module wfhd_loader #(
  parameter int NODES        = wfhd_pkg::NODES_DEF,
  parameter int MAX_CODE_LEN = wfhd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wfhd_pkg::wfhd_cmd_t                cmd,
  input  logic [wfhd_pkg::CODE_W-1:0]        code_bits,
  input  logic [wfhd_pkg::LEN_W-1:0]         code_length,
  input  logic [wfhd_pkg::SYM_W-1:0]         symbol,
  input  logic [2*$clog2(NODES)-1:0]         links_rd,
  output logic                               rd_en,
  output logic [$clog2(NODES)-1:0]           rd_addr,
  output logic                               lk_we,
  output logic [$clog2(NODES)-1:0]           lk_waddr,
  output logic [2*$clog2(NODES)-1:0]         lk_wdata,
  output logic                               sy_we,
  output logic [$clog2(NODES)-1:0]           sy_waddr,
  output logic [wfhd_pkg::SYM_W-1:0]         sy_wdata,
  output logic [2*$clog2(NODES)-1:0]         root_links,
  output logic                               busy
);

  localparam int NW = $clog2(NODES);
  localparam int FW = $clog2(NODES + 1);
  localparam int IW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW = (MAX_CODE_LEN > wfhd_pkg::CODE_W) ? MAX_CODE_LEN : wfhd_pkg::CODE_W;
  localparam int BW = $clog2(CW);

  typedef enum logic [3:0] {
    LD_IDLE = 4'b0001,
    LD_READ = 4'b0010,
    LD_EVAL = 4'b0100,
    LD_END  = 4'b1000
  } ld_state_t;

  ld_state_t              st_r, st_nxt;
  logic [NW-1:0]          node_r, node_nxt;
  logic [IW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          bits_r, bits_nxt;
  logic [wfhd_pkg::SYM_W-1:0] sym_r, sym_nxt;
  logic                   fresh_r, fresh_nxt;
  logic [FW-1:0]          free_r, free_nxt;
  logic [2*NW-1:0]        root_r, root_nxt;

  logic [2*NW-1:0]        word;
  logic [2*NW-1:0]        nword;
  logic [BW-1:0]          idx;
  logic                   b;
  logic [NW-1:0]          child;
  logic                   len_ok;

  assign busy       = (st_r != LD_IDLE);
  assign root_links = root_r;
  assign sy_wdata   = sym_r;
  assign sy_waddr   = node_r;
  assign rd_addr    = node_r;
  assign lk_waddr   = node_r;

  always_comb begin
    st_nxt    = st_r;
    node_nxt  = node_r;
    i_nxt     = i_r;
    bits_nxt  = bits_r;
    sym_nxt   = sym_r;
    fresh_nxt = fresh_r;
    free_nxt  = free_r;
    root_nxt  = root_r;
    rd_en     = 1'b0;
    lk_we     = 1'b0;
    lk_wdata  = '0;
    sy_we     = 1'b0;
    len_ok    = (code_length != '0) && (int'(code_length) <= MAX_CODE_LEN);
    idx       = BW'(i_r - 1'b1);
    b         = bits_r[idx];
    if (node_r == '0) begin
      word = root_r;
    end else if (fresh_r) begin
      word = '0;
    end else begin
      word = links_rd;
    end
    child = b ? word[2*NW-1:NW] : word[NW-1:0];
    nword = word;
    if (b) begin
      nword[2*NW-1:NW] = free_r[NW-1:0];
    end else begin
      nword[NW-1:0] = free_r[NW-1:0];
    end
    case (st_r)
      LD_IDLE: begin
        if (cmd.load && len_ok) begin
          node_nxt  = '0;
          i_nxt     = IW'(code_length);
          bits_nxt  = CW'(code_bits);
          sym_nxt   = symbol;
          fresh_nxt = 1'b0;
          st_nxt    = LD_EVAL;
        end
      end
      LD_READ: begin
        // clear a freshly created node while fetching its links
        lk_we  = fresh_r;
        rd_en  = 1'b1;
        st_nxt = LD_EVAL;
      end
      LD_EVAL: begin
        if (child != '0) begin
          node_nxt  = child;
          fresh_nxt = 1'b0;
          st_nxt    = (i_r == IW'(1)) ? LD_END : LD_READ;
          i_nxt     = i_r - 1'b1;
        end else if (free_r == FW'(NODES)) begin
          st_nxt = LD_IDLE;
        end else begin
          if (node_r == '0) begin
            root_nxt = nword;
          end else begin
            lk_we    = 1'b1;
            lk_wdata = nword;
          end
          node_nxt  = free_r[NW-1:0];
          free_nxt  = free_r + 1'b1;
          fresh_nxt = 1'b1;
          st_nxt    = (i_r == IW'(1)) ? LD_END : LD_READ;
          i_nxt     = i_r - 1'b1;
        end
      end
      LD_END: begin
        lk_we  = fresh_r;
        sy_we  = 1'b1;
        st_nxt = LD_IDLE;
      end
      default: begin
        st_nxt = LD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= LD_IDLE;
      free_r  <= FW'(1);
      root_r  <= '0;
      fresh_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      free_r  <= free_nxt;
      root_r  <= root_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    i_r    <= i_nxt;
    bits_r <= bits_nxt;
    sym_r  <= sym_nxt;
  end

endmodule
`default_nettype wire

>>> src/wfhd_decoder.sv
// Bit engine: skip, type, raw and tree-walk phases, channel sums and result staging.
`timescale 1ns / 1ps
`default_nettype none
module wfhd_decoder #(
  parameter int NODES    = wfhd_pkg::NODES_DEF,
  parameter int CHANNELS = wfhd_pkg::CHANNELS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  wfhd_pkg::wfhd_cmd_t                            cmd,
  input  logic [wfhd_pkg::BYTE_W-1:0]                    data_byte,
  input  logic [wfhd_pkg::SKIP_W-1:0]                    skip_bits,
  input  logic [2*$clog2(NODES)-1:0]                     root_links,
  input  logic [2*$clog2(NODES)-1:0]                     links_rd,
  input  logic [wfhd_pkg::SYM_W-1:0]                     sym_rd,
  output logic                                           rd_en,
  output logic [$clog2(NODES)-1:0]                       rd_addr,
  output logic                                           busy,
  output logic                                           out_v,
  output logic [wfhd_pkg::SYM_W-1:0]                     out_sum,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] out_chan,
  output logic                                           out_err,
  output logic                                           out_last
);

  localparam int NW  = $clog2(NODES);
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW  = $clog2(wfhd_pkg::BYTE_W + 1);
  localparam int SW  = wfhd_pkg::SYM_W;
  localparam int RB  = wfhd_pkg::RAW_BITS;

  typedef enum logic [1:0] {
    DC_IDLE = 2'b01,
    DC_RUN  = 2'b10
  } dc_state_t;

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_RAW  = 4'b0100,
    PH_WALK = 4'b1000
  } phase_t;

  dc_state_t                    st_r, st_nxt;
  phase_t                       ph_r, ph_nxt, ph;
  logic [wfhd_pkg::SKIP_W-1:0]  cnt_r, cnt_nxt;
  logic [RB-1:0]                raw_r, raw_nxt;
  logic [CHW-1:0]               chan_r, chan_nxt;
  logic [wfhd_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic [LW-1:0]                left_r, left_nxt;
  logic                         pend_r, pend_nxt;
  logic [2*NW-1:0]              cur_r, cur_nxt, cur;
  logic                         hold_v_r, hold_v_nxt;
  logic [SW-1:0]                hold_sum_r, hold_sum_nxt;
  logic [CHW-1:0]               hold_chan_r, hold_chan_nxt;
  logic                         hold_err_r, hold_err_nxt;
  logic                         out_v_r, out_v_nxt;
  logic [SW-1:0]                out_sum_r, out_sum_nxt;
  logic [CHW-1:0]               out_chan_r, out_chan_nxt;
  logic                         out_err_r, out_err_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [SW-1:0]                sum_r [CHANNELS];

  logic                         res_v;
  logic [SW-1:0]                res_sum;
  logic                         res_err;
  logic                         sum_we;
  logic [SW-1:0]                sum_wd;
  logic                         b;
  logic [NW-1:0]                child;
  logic [CHW-1:0]               chan_adv;

  assign busy     = (st_r != DC_IDLE);
  assign out_v    = out_v_r;
  assign out_sum  = out_sum_r;
  assign out_chan = out_chan_r;
  assign out_err  = out_err_r;
  assign out_last = out_last_r;
  assign rd_addr  = child;
  assign chan_adv = (chan_r == CHW'(CHANNELS - 1)) ? '0 : chan_r + 1'b1;

  always_comb begin
    st_nxt        = st_r;
    ph            = ph_r;
    cnt_nxt       = cnt_r;
    raw_nxt       = raw_r;
    chan_nxt      = chan_r;
    byte_nxt      = byte_r;
    left_nxt      = left_r;
    pend_nxt      = pend_r;
    cur           = cur_r;
    hold_v_nxt    = hold_v_r;
    hold_sum_nxt  = hold_sum_r;
    hold_chan_nxt = hold_chan_r;
    hold_err_nxt  = hold_err_r;
    out_v_nxt     = 1'b0;
    out_sum_nxt   = hold_sum_r;
    out_chan_nxt  = hold_chan_r;
    out_err_nxt   = hold_err_r;
    out_last_nxt  = 1'b0;
    res_v         = 1'b0;
    res_sum       = sum_r[chan_r];
    res_err       = 1'b0;
    sum_we        = 1'b0;
    sum_wd        = sum_r[chan_r] + sym_rd;
    rd_en         = 1'b0;
    b             = byte_r[wfhd_pkg::BYTE_W-1];
    child         = '0;
    case (st_r)
      DC_IDLE: begin
        if (cmd.data) begin
          st_nxt   = DC_RUN;
          byte_nxt = data_byte;
          left_nxt = LW'(wfhd_pkg::BYTE_W);
        end
        if (cmd.restart) begin
          ph       = PH_SKIP;
          cnt_nxt  = '0;
          raw_nxt  = '0;
          chan_nxt = '0;
          pend_nxt = 1'b0;
        end
      end
      DC_RUN: begin
        // resolve the node read issued by the previous walk bit
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (links_rd == '0) begin
            sum_we   = 1'b1;
            res_v    = 1'b1;
            res_sum  = sum_wd;
            chan_nxt = chan_adv;
            ph       = PH_TYPE;
          end else begin
            cur = links_rd;
          end
        end
        if (left_r != '0) begin
          byte_nxt = byte_r << 1;
          left_nxt = left_r - 1'b1;
          if ((ph == PH_SKIP) && (cnt_r < skip_bits)) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            case (ph)
              PH_SKIP, PH_TYPE: begin
                if (!b) begin
                  ph      = PH_RAW;
                  raw_nxt = '0;
                  cnt_nxt = '0;
                end else begin
                  ph  = PH_WALK;
                  cur = root_links;
                end
              end
              PH_RAW: begin
                raw_nxt = {raw_r[RB-2:0], b};
                if (cnt_r >= wfhd_pkg::SKIP_W'(RB - 1)) begin
                  sum_we   = 1'b1;
                  sum_wd   = SW'(raw_nxt);
                  res_v    = 1'b1;
                  res_sum  = SW'(raw_nxt);
                  chan_nxt = chan_adv;
                  cnt_nxt  = '0;
                  ph       = PH_TYPE;
                end else begin
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
              PH_WALK: begin
                child = b ? cur[2*NW-1:NW] : cur[NW-1:0];
                if (child == '0) begin
                  res_v   = 1'b1;
                  res_err = 1'b1;
                  ph      = PH_TYPE;
                end else begin
                  rd_en    = 1'b1;
                  pend_nxt = 1'b1;
                end
              end
              default: begin
                ph = PH_TYPE;
              end
            endcase
          end
        end else if (!pend_r) begin
          // byte done: release the staged word as the final one
          out_v_nxt    = hold_v_r;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          st_nxt       = DC_IDLE;
        end
      end
      default: begin
        st_nxt = DC_IDLE;
      end
    endcase
    ph_nxt  = ph;
    cur_nxt = cur;
    if (res_v) begin
      out_v_nxt     = hold_v_r;
      hold_v_nxt    = 1'b1;
      hold_sum_nxt  = res_sum;
      hold_chan_nxt = chan_r;
      hold_err_nxt  = res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= DC_IDLE;
      ph_r     <= PH_SKIP;
      cnt_r    <= '0;
      raw_r    <= '0;
      chan_r   <= '0;
      left_r   <= '0;
      pend_r   <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      raw_r    <= raw_nxt;
      chan_r   <= chan_nxt;
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    cur_r       <= cur_nxt;
    hold_sum_r  <= hold_sum_nxt;
    hold_chan_r <= hold_chan_nxt;
    hold_err_r  <= hold_err_nxt;
    out_sum_r   <= out_sum_nxt;
    out_chan_r  <= out_chan_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int k = 0; k < CHANNELS; k++) begin
        sum_r[k] <= '0;
      end
    end else if (sum_we) begin
      sum_r[chan_r] <= sum_wd;
    end
  end

endmodule
`default_nettype wire

>>> src/waveform_huffman_delta_decoder_unit.sv
// Top level of the multi-channel prefix-code waveform decoder.
//
//  channel | handshake            | word
//  --------+----------------------+-----------------------------------------------
//  input   | start / busy         | in_opcode, in_code_bits, in_code_length,
//          |                      | in_symbol, in_data_byte
//  config  | cfg_valid/cfg_ready  | cfg_data (skip bits)
//  result  | out_strobe (1 cycle) | out_sample_value, out_channel,
//          |                      | out_decode_error, out_last
//
// Data byte: one node-table read per walk bit, resolved in the cycle that takes the
// following bit. Code load: each code bit after the first is a read step, then an
// evaluate/extend step, and a final step writes the symbol; restart leaves busy low.
// Reset is synchronous; the node table is tracked by the free-node count and needs
// no clearing pass. Results cannot be stalled; up to 4 words per byte.
`timescale 1ns / 1ps
`default_nettype none
module waveform_huffman_delta_decoder_unit #(
  parameter int NODES        = wfhd_pkg::NODES_DEF,
  parameter int CHANNELS     = wfhd_pkg::CHANNELS_DEF,
  parameter int MAX_CODE_LEN = wfhd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               start,
  output logic                                               busy,
  input  logic [wfhd_pkg::OPC_W-1:0]                         in_opcode,
  input  logic [wfhd_pkg::CODE_W-1:0]                        in_code_bits,
  input  logic [wfhd_pkg::LEN_W-1:0]                         in_code_length,
  input  logic signed [wfhd_pkg::SYM_W-1:0]                  in_symbol,
  input  logic [wfhd_pkg::BYTE_W-1:0]                        in_data_byte,
  input  logic                                               cfg_valid,
  output logic                                               cfg_ready,
  input  logic [wfhd_pkg::SKIP_W-1:0]                        cfg_data,
  output logic                                               out_strobe,
  output logic signed [wfhd_pkg::SYM_W-1:0]                  out_sample_value,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] out_channel,
  output logic                                               out_decode_error,
  output logic                                               out_last
);

  localparam int NW = $clog2(NODES);

  wfhd_pkg::wfhd_cmd_t             cmd;
  logic                            accept;
  logic [wfhd_pkg::SKIP_W-1:0]     skip_r;
  logic                            ld_busy, dc_busy;

  logic                            ld_rd_en, dc_rd_en;
  logic [NW-1:0]                   ld_rd_addr, dc_rd_addr;
  logic                            lk_we;
  logic [NW-1:0]                   lk_waddr;
  logic [2*NW-1:0]                 lk_wdata;
  logic [2*NW-1:0]                 links_rd;
  logic [2*NW-1:0]                 root_links;
  logic                            sy_we;
  logic [NW-1:0]                   sy_waddr;
  logic [wfhd_pkg::SYM_W-1:0]      sy_wdata;
  logic [wfhd_pkg::SYM_W-1:0]      sym_rd;
  logic [wfhd_pkg::SYM_W-1:0]      dc_sum;

  assign accept      = start && !busy;
  assign cmd.load    = accept && (in_opcode == wfhd_pkg::OP_LOAD);
  assign cmd.data    = accept && (in_opcode == wfhd_pkg::OP_DATA);
  assign cmd.restart = accept && (in_opcode == wfhd_pkg::OP_RESTART);
  assign busy        = ld_busy || dc_busy;
  assign cfg_ready   = 1'b1;
  assign out_sample_value = signed'(dc_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      skip_r <= cfg_data;
    end
  end

  wfhd_ram #(
    .WIDTH (2 * NW),
    .DEPTH (NODES)
  ) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (ld_rd_en || dc_rd_en),
    .raddr (dc_rd_en ? dc_rd_addr : ld_rd_addr),
    .rdata (links_rd)
  );

  wfhd_ram #(
    .WIDTH (wfhd_pkg::SYM_W),
    .DEPTH (NODES)
  ) u_symbols (
    .clk   (clk),
    .we    (sy_we),
    .waddr (sy_waddr),
    .wdata (sy_wdata),
    .re    (dc_rd_en),
    .raddr (dc_rd_addr),
    .rdata (sym_rd)
  );

  wfhd_loader #(
    .NODES        (NODES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_loader (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .code_bits   (in_code_bits),
    .code_length (in_code_length),
    .symbol      (unsigned'(in_symbol)),
    .links_rd    (links_rd),
    .rd_en       (ld_rd_en),
    .rd_addr     (ld_rd_addr),
    .lk_we       (lk_we),
    .lk_waddr    (lk_waddr),
    .lk_wdata    (lk_wdata),
    .sy_we       (sy_we),
    .sy_waddr    (sy_waddr),
    .sy_wdata    (sy_wdata),
    .root_links  (root_links),
    .busy        (ld_busy)
  );

  wfhd_decoder #(
    .NODES    (NODES),
    .CHANNELS (CHANNELS)
  ) u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_byte  (in_data_byte),
    .skip_bits  (skip_r),
    .root_links (root_links),
    .links_rd   (links_rd),
    .sym_rd     (sym_rd),
    .rd_en      (dc_rd_en),
    .rd_addr    (dc_rd_addr),
    .busy       (dc_busy),
    .out_v      (out_strobe),
    .out_sum    (dc_sum),
    .out_chan   (out_channel),
    .out_err    (out_decode_error),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

>>> dv/wfhd_checker.sv
// Result checker for the waveform prefix-code decoder: predicts sample words and compares them.
`timescale 1ns / 1ps
module wfhd_checker #(
  parameter int NODES        = wfhd_pkg::NODES_DEF,
  parameter int CHANNELS     = wfhd_pkg::CHANNELS_DEF,
  parameter int MAX_CODE_LEN = wfhd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               start,
  input  logic                                               busy,
  input  logic [wfhd_pkg::OPC_W-1:0]                         in_opcode,
  input  logic [wfhd_pkg::CODE_W-1:0]                        in_code_bits,
  input  logic [wfhd_pkg::LEN_W-1:0]                         in_code_length,
  input  logic signed [wfhd_pkg::SYM_W-1:0]                  in_symbol,
  input  logic [wfhd_pkg::BYTE_W-1:0]                        in_data_byte,
  input  logic                                               cfg_valid,
  input  logic                                               cfg_ready,
  input  logic [wfhd_pkg::SKIP_W-1:0]                        cfg_data,
  input  logic                                               out_strobe,
  input  logic signed [wfhd_pkg::SYM_W-1:0]                  out_sample_value,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] out_channel,
  input  logic                                               out_decode_error,
  input  logic                                               out_last,
  output int                                                 fail_count,
  output int                                                 pending_words
);
  import wfhd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {SCAN_SKIP, SCAN_TYPE, SCAN_RAW, SCAN_WALK} scan_phase_e;

  typedef struct packed {
    logic signed [SYM_W-1:0] value;
    logic [CH_W-1:0]         chan;
    logic                    err;
    logic                    last;
  } sample_word_t;

  int unsigned         child_tbl [NODES][2];
  logic [SYM_W-1:0]    sym_tbl [NODES];
  int unsigned         free_cnt;
  logic [SYM_W-1:0]    chan_sum [CHANNELS];
  int unsigned         chan_idx;
  scan_phase_e         phase;
  logic [RAW_BITS-1:0] raw_acc;
  int unsigned         bit_cnt;
  int unsigned         walk_at;
  logic [SKIP_W-1:0]   skip_len;
  sample_word_t        predicted_samples[$];
  sample_word_t        item_samples[$];
  int                  mismatch_cnt;

  initial begin
    fail_count    = 0;
    pending_words = 0;
    mismatch_cnt  = 0;
  end

  task automatic clear_stream();
    foreach (chan_sum[c]) chan_sum[c] = '0;
    chan_idx = 0;
    phase    = SCAN_SKIP;
    raw_acc  = '0;
    bit_cnt  = 0;
    walk_at  = 0;
  endtask

  task automatic emit_sample(input logic err);
    sample_word_t w;
    w.value = chan_sum[chan_idx];
    w.chan  = chan_idx[CH_W-1:0];
    w.err   = err;
    w.last  = 1'b0;
    item_samples.push_back(w);
    if (!err) chan_idx = (chan_idx + 1) % CHANNELS;
  endtask

  task automatic insert_code(input logic [CODE_W-1:0] bits, input int unsigned len,
                             input logic [SYM_W-1:0] sym);
    int unsigned at;
    int unsigned nxt;
    int unsigned b;
    at = 0;
    if (len == 0 || len > MAX_CODE_LEN) return;
    for (int i = len; i > 0; i--) begin
      b = (i - 1 < CODE_W) ? bits[i-1] : 0;
      nxt = child_tbl[at][b];
      if (nxt == 0) begin
        if (free_cnt >= NODES) return;
        nxt = free_cnt;
        free_cnt++;
        child_tbl[nxt][0] = 0;
        child_tbl[nxt][1] = 0;
        child_tbl[at][b] = nxt;
      end
      at = nxt;
    end
    sym_tbl[at] = sym;
  endtask

  task automatic decode_bit(input logic b);
    int unsigned nxt;
    if (phase == SCAN_SKIP) begin
      if (bit_cnt < skip_len) begin
        bit_cnt++;
        return;
      end
      phase = SCAN_TYPE;
    end
    case (phase)
      SCAN_TYPE: begin
        if (!b) begin
          phase   = SCAN_RAW;
          raw_acc = '0;
          bit_cnt = 0;
        end else begin
          phase   = SCAN_WALK;
          walk_at = 0;
        end
      end
      SCAN_RAW: begin
        raw_acc = {raw_acc[RAW_BITS-2:0], b};
        bit_cnt++;
        if (bit_cnt >= RAW_BITS) begin
          chan_sum[chan_idx] = {{(SYM_W-RAW_BITS){1'b0}}, raw_acc};
          emit_sample(1'b0);
          bit_cnt = 0;
          phase   = SCAN_TYPE;
        end
      end
      SCAN_WALK: begin
        nxt = child_tbl[walk_at][b];
        if (nxt == 0) begin
          emit_sample(1'b1);
          walk_at = 0;
          phase   = SCAN_TYPE;
        end else if (child_tbl[nxt][0] == 0 && child_tbl[nxt][1] == 0) begin
          chan_sum[chan_idx] = chan_sum[chan_idx] + sym_tbl[nxt];
          emit_sample(1'b0);
          walk_at = 0;
          phase   = SCAN_TYPE;
        end else begin
          walk_at = nxt;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_proc
    sample_word_t want;
    sample_word_t tail;
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        child_tbl[n][0] = 0;
        child_tbl[n][1] = 0;
        sym_tbl[n]      = '0;
      end
      free_cnt = 1;
      skip_len = '0;
      clear_stream();
      predicted_samples.delete();
    end else begin
      if (out_strobe) begin
        if (predicted_samples.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] unexpected word: value %0d ch %0d err %0b last %0b", $time,
                     out_sample_value, out_channel, out_decode_error, out_last);
        end else begin
          want = predicted_samples.pop_front();
          if (out_sample_value !== want.value || out_channel !== want.chan ||
              out_decode_error !== want.err || out_last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"[%0t] word mismatch: expected value %0d ch %0d err %0b last %0b,",
                        " got value %0d ch %0d err %0b last %0b"}, $time,
                       want.value, want.chan, want.err, want.last,
                       out_sample_value, out_channel, out_decode_error, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) skip_len = cfg_data;
      if (start && !busy) begin
        item_samples.delete();
        case (in_opcode)
          OP_LOAD:    insert_code(in_code_bits, in_code_length, in_symbol);
          OP_DATA:    for (int k = BYTE_W - 1; k >= 0; k--) decode_bit(in_data_byte[k]);
          OP_RESTART: clear_stream();
          default: ;
        endcase
        if (item_samples.size() > 0) begin
          tail = item_samples.pop_back();
          tail.last = 1'b1;
          item_samples.push_back(tail);
        end
        foreach (item_samples[j]) predicted_samples.push_back(item_samples[j]);
      end
    end
    fail_count    <= mismatch_cnt;
    pending_words <= predicted_samples.size();
  end

endmodule

>>> dv/tb_waveform_huffman_delta_decoder_unit.sv
// Testbench top: drives code loads, stream bytes and skip settings into the decoder and reports.
`timescale 1ns / 1ps
module tb_waveform_huffman_delta_decoder_unit;
  import wfhd_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int CH_W         = $clog2(CHANNELS_DEF);
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 65;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  logic                    clk;
  logic                    rst_n            = 1'b0;
  logic                    start            = 1'b0;
  logic                    busy;
  logic [OPC_W-1:0]        in_opcode        = '0;
  logic [CODE_W-1:0]       in_code_bits     = '0;
  logic [LEN_W-1:0]        in_code_length   = '0;
  logic signed [SYM_W-1:0] in_symbol        = '0;
  logic [BYTE_W-1:0]       in_data_byte     = '0;
  logic                    cfg_valid        = 1'b0;
  logic                    cfg_ready;
  logic [SKIP_W-1:0]       cfg_data         = '0;
  logic                    out_strobe;
  logic signed [SYM_W-1:0] out_sample_value;
  logic [CH_W-1:0]         out_channel;
  logic                    out_decode_error;
  logic                    out_last;
  int                      fail_count;
  int                      pending_words;

  int                      stall_cycles = 0;
  int                      idle_pct     = 0;
  int                      words_sent   = 0;
  logic [SKIP_W-1:0]       skip_now     = '0;
  int                      code_nodes[int];
  bit                      stream_bits[$];

  waveform_huffman_delta_decoder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_code_bits     (in_code_bits),
    .in_code_length   (in_code_length),
    .in_symbol        (in_symbol),
    .in_data_byte     (in_data_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_sample_value (out_sample_value),
    .out_channel      (out_channel),
    .out_decode_error (out_decode_error),
    .out_last         (out_last)
  );

  wfhd_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_code_bits     (in_code_bits),
    .in_code_length   (in_code_length),
    .in_symbol        (in_symbol),
    .in_data_byte     (in_data_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_sample_value (out_sample_value),
    .out_channel      (out_channel),
    .out_decode_error (out_decode_error),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending_words    (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** waveform_huffman_delta_decoder_unit: FAILED **");
      $finish;
    end
  end

  function automatic int node_key(input int unsigned depth, input int unsigned prefix);
    return (depth << 20) | prefix;
  endfunction

  function automatic int unsigned known_depth(input logic [CODE_W-1:0] used,
                                              input int unsigned len);
    int unsigned d;
    d = 0;
    while (d < len && code_nodes.exists(node_key(d + 1, used >> (len - d - 1)))) d++;
    return d;
  endfunction

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [CODE_W-1:0] bits,
                           input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym,
                           input logic [BYTE_W-1:0] data);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_code_bits   <= bits;
    in_code_length <= len;
    in_symbol      <= sym;
    in_data_byte   <= data;
    do @(posedge clk); while (busy);
    if (op != OP_UNUSED) words_sent++;
  endtask

  // hold node creation inside the table; truncate a code that would overflow it, unless the table is already full
  task automatic load_code(input logic [CODE_W-1:0] bits, input int unsigned len,
                           input logic [SYM_W-1:0] sym);
    logic [CODE_W-1:0] used;
    int unsigned       d;
    int unsigned       room;
    int unsigned       n_len;
    if (len == 0 || len > MAX_CODE_LEN_DEF) begin
      send_word(OP_LOAD, bits, len, sym, $urandom);
      return;
    end
    used  = bits & CODE_W'((32'd1 << len) - 32'd1);
    n_len = len;
    d     = known_depth(used, n_len);
    room  = NODES - 1 - code_nodes.num();
    if (room > 0 && n_len - d > room) begin
      used  = used >> (n_len - d - room);
      n_len = d + room;
      bits  = used;
    end
    if (n_len - d <= room) begin
      for (int k = d + 1; k <= n_len; k++) code_nodes[node_key(k, used >> (n_len - k))] = 1;
    end
    send_word(OP_LOAD, bits, n_len, sym, $urandom);
  endtask

  task automatic add_raw();
    stream_bits.push_back(1'b0);
    repeat (RAW_BITS) stream_bits.push_back($urandom_range(0, 1));
  endtask

  task automatic add_walk();
    int unsigned depth;
    int unsigned prefix;
    int unsigned pick;
    bit          has0;
    bit          has1;
    bit          done;
    depth  = 0;
    prefix = 0;
    done   = 1'b0;
    stream_bits.push_back(1'b1);
    while (!done) begin
      has0 = code_nodes.exists(node_key(depth + 1, prefix << 1));
      has1 = code_nodes.exists(node_key(depth + 1, (prefix << 1) | 1));
      if (!has0 && !has1) begin
        if (depth == 0) stream_bits.push_back($urandom_range(0, 1));
        done = 1'b1;
      end else if ((!has0 || !has1) && $urandom_range(0, 15) == 0) begin
        stream_bits.push_back(has0);
        done = 1'b1;
      end else begin
        pick = (has0 && has1) ? $urandom_range(0, 1) : has1;
        stream_bits.push_back(pick[0]);
        prefix = (prefix << 1) | pick;
        depth++;
      end
    end
  endtask

  task automatic send_sequence(input int unsigned n_samples);
    logic [BYTE_W-1:0] data;
    send_word(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
    repeat (skip_now) stream_bits.push_back($urandom_range(0, 1));
    repeat (n_samples) begin
      if (code_nodes.num() > 0 && $urandom_range(0, 99) < 65) add_walk();
      else add_raw();
    end
    while (stream_bits.size() % BYTE_W != 0) stream_bits.push_back($urandom_range(0, 1));
    while (stream_bits.size() > 0) begin
      for (int k = 0; k < BYTE_W; k++) data = {data[BYTE_W-2:0], stream_bits.pop_front()};
      send_word(OP_DATA, $urandom, $urandom, $urandom, data);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: load_code($urandom, $urandom_range(0, 31), $urandom);
      1: send_word(OP_DATA, $urandom, $urandom, $urandom, $urandom);
      2: send_word(OP_RESTART, $urandom, $urandom, $urandom, $urandom);
      default: send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endcase
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_skip(input logic [SKIP_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    skip_now = value;
  endtask

  task automatic random_phase(input int unsigned skip, input int pct);
    int          first_word;
    int unsigned pick;
    write_skip(skip);
    idle_pct   = pct;
    first_word = words_sent;
    while (words_sent - first_word < PHASE_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        load_code($urandom,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5),
                  $urandom);
      end else if (pick < 30) begin
        send_noise();
      end else begin
        send_sequence(($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_DATA, '0, '0, '0, 8'hFF);
    send_word(OP_DATA, '1, '1, '1, 8'h00);
    send_word(OP_DATA, '0, '0, '0, 8'hA5);
    send_word(OP_UNUSED, '1, '1, '1, '1);
    send_word(OP_LOAD, 16'hFFFF, 5'd0, 16'h1234, '0);
    send_word(OP_LOAD, 16'hFFFF, 5'd17, 16'h1234, '0);
    send_word(OP_LOAD, 16'hAAAA, 5'd31, 16'h4321, '0);
    load_code(16'hFFFE, 1, 16'h7FFF);
    load_code(16'h0002, 2, 16'h8000);
    load_code(16'hFFFF, 16, 16'hFFFF);
    load_code(16'h0003, 2, 16'h0005);
    send_word(OP_RESTART, '1, '1, '1, '1);
    send_word(OP_DATA, '0, '0, '0, 8'hB7);
    send_word(OP_DATA, '0, '0, '0, 8'h3F);
    send_word(OP_DATA, '0, '0, '0, 8'hFF);
    send_word(OP_DATA, '0, '0, '0, 8'hFF);
    send_word(OP_DATA, '0, '0, '0, 8'hFF);
    send_word(OP_DATA, '0, '0, '0, 8'h00);
    send_word(OP_DATA, '0, '0, '0, 8'h01);

    random_phase(31, 0);
    random_phase(0, 45);
    random_phase($urandom_range(1, 30), 0);
    random_phase($urandom_range(1, 30), 9);

    // fill the node table, then push loads that need nodes it no longer has
    while (code_nodes.num() < NODES - 1) load_code($urandom, MAX_CODE_LEN_DEF, $urandom);
    repeat (4) load_code($urandom, MAX_CODE_LEN_DEF, $urandom);
    send_sequence(20);
    send_sequence(3);

    settle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("** waveform_huffman_delta_decoder_unit: PASSED **");
    end else begin
      $display("** waveform_huffman_delta_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
src/wfhd_pkg.sv
src/wfhd_ram.sv
src/wfhd_loader.sv
src/wfhd_decoder.sv
src/waveform_huffman_delta_decoder_unit.sv
dv/wfhd_checker.sv
dv/tb_waveform_huffman_delta_decoder_unit.sv
